/* rtl/core/ipda_pkg.sv */
// shared types, constants and helpers for the ipv4 dotted address parser
package ipda_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned NPARTS  = 3;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [ADDR_W-1:0] LIMIT_TWO   = 32'h00ff_ffff;
  localparam logic [ADDR_W-1:0] LIMIT_THREE = 32'h0000_ffff;
  localparam logic [ADDR_W-1:0] LIMIT_FOUR  = 32'h0000_00ff;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_HEXL,
    CLS_X,
    CLS_DOT,
    CLS_END,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LEAD0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // one classified character
  typedef struct packed {
    cls_t       cls;
    logic [3:0] val;
    logic       last;
  } qent_t;

  // parser state handed to the packing stage at the end of a string
  typedef struct packed {
    logic [ADDR_W-1:0]             accum;
    logic [NPARTS-1:0][ADDR_W-1:0] parts;
    logic [1:0]                    count;
    phase_t                        phase;
    logic                          err;
  } fin_t;

  typedef struct packed {
    logic              rej;
    logic [ADDR_W-1:0] value;
  } pack_res_t;

  // range check of the last part and packing of the earlier ones
  // earlier parts are shifted into place whole, so their high bits spill upwards
  function automatic pack_res_t ipda_finish(input logic [ADDR_W-1:0] v,
                                            input logic [NPARTS-1:0][ADDR_W-1:0] p,
                                            input logic [1:0] cnt);
    pack_res_t r;
    r.rej   = 1'b0;
    r.value = v;
    unique case (cnt)
      2'd0: r.value = v;
      2'd1: begin
        r.rej   = (v > LIMIT_TWO);
        r.value = v | {p[0][7:0], 24'h0};
      end
      2'd2: begin
        r.rej   = (v > LIMIT_THREE);
        r.value = v | {p[0][7:0], 24'h0} | {p[1][15:0], 16'h0};
      end
      default: begin
        r.rej   = (v > LIMIT_FOUR);
        r.value = v | {p[0][7:0], 24'h0} | {p[1][15:0], 16'h0}
                    | {p[2][23:0], 8'h0};
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ipda_front.sv */
// character classifier feeding the item queue
module ipda_front import ipda_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_is_last,
  output logic       push,
  output qent_t      push_ent,
  input  logic       q_ready
);

  logic [7:0] up;
  logic       blank;

  always_comb begin
    up    = (in_ch >= CH_LO_A && in_ch <= CH_LO_Z) ? in_ch - CASE_OFS : in_ch;
    blank = (in_ch == CH_SPACE) || (in_ch >= CH_TAB && in_ch <= CH_CR);
    push_ent.last = in_is_last;
    push_ent.val  = in_ch[3:0];
    priority if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      push_ent.cls = CLS_DIGIT;
    end else if (up >= CH_UP_A && up <= CH_UP_F) begin
      push_ent.cls = CLS_HEXL;
      push_ent.val = up[3:0] + 4'd9;
    end else if (up == CH_UP_X) begin
      push_ent.cls = CLS_X;
    end else if (in_ch == CH_DOT) begin
      push_ent.cls = CLS_DOT;
    end else if (in_ch == CH_NUL || blank) begin
      push_ent.cls = CLS_END;
    end else begin
      push_ent.cls = CLS_OTHER;
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid;

endmodule

/* rtl/core/ipda_queue.sv */
// short queue of classified items between front and back
module ipda_queue import ipda_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  q_ready,
  output logic  q_valid,
  output qent_t q_ent,
  input  logic  pop
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_ent   = mem_r[rd_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

endmodule

/* rtl/core/ipda_back.sv */
// parser state machine: one classified item per cycle unless the packing stage stalls
module ipda_back import ipda_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  qent_t q_ent,
  output logic  pop,
  output logic  fin_valid,
  output fin_t  fin,
  input  logic  fin_ready
);

  logic [ADDR_W-1:0]             accum_r, accum_nxt;
  logic [NPARTS-1:0][ADDR_W-1:0] parts_r, parts_nxt;
  logic [1:0]                    count_r, count_nxt;
  radix_t                        radix_r, radix_nxt;
  phase_t                        phase_r, phase_nxt;
  logic                          err_r, err_nxt;
  logic                          fin_valid_r, fin_valid_nxt;
  fin_t                          fin_r, fin_nxt;

  radix_t     eff_radix;
  logic       run_digits;
  pack_res_t  pr;

  assign pop       = q_valid && (!q_ent.last || !fin_valid_r || fin_ready);
  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

  always_comb begin
    accum_nxt = accum_r;
    parts_nxt = parts_r;
    count_nxt = count_r;
    radix_nxt = radix_r;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    // a leading zero not followed by x switches the part to octal
    eff_radix  = (phase_r == PH_LEAD0) ? RADIX_OCT : radix_r;
    run_digits = (phase_r == PH_DIGITS) || (phase_r == PH_LEAD0 && q_ent.cls != CLS_X);
    pr         = ipda_finish(accum_r, parts_r, count_r);

    unique case (phase_r)
      PH_FIRST: begin
        if (q_ent.cls != CLS_DIGIT) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (q_ent.val == 4'd0) begin
          accum_nxt = '0;
          phase_nxt = PH_LEAD0;
        end else begin
          radix_nxt = RADIX_DEC;
          accum_nxt = {{(ADDR_W-4){1'b0}}, q_ent.val};
          phase_nxt = PH_DIGITS;
        end
      end
      PH_LEAD0: begin
        phase_nxt = PH_DIGITS;
        radix_nxt = (q_ent.cls == CLS_X) ? RADIX_HEX : RADIX_OCT;
      end
      PH_DIGITS: ;
      PH_DONE: ;
      default: ;
    endcase

    if (run_digits) begin
      priority if (q_ent.cls == CLS_DIGIT) begin
        unique case (eff_radix)
          RADIX_HEX: accum_nxt = {accum_r[ADDR_W-5:0], 4'h0}
                                 + {{(ADDR_W-4){1'b0}}, q_ent.val};
          RADIX_OCT: accum_nxt = {accum_r[ADDR_W-4:0], 3'h0}
                                 + {{(ADDR_W-4){1'b0}}, q_ent.val};
          default:   accum_nxt = {accum_r[ADDR_W-4:0], 3'h0}
                                 + {accum_r[ADDR_W-2:0], 1'b0}
                                 + {{(ADDR_W-4){1'b0}}, q_ent.val};
        endcase
      end else if (q_ent.cls == CLS_HEXL && eff_radix == RADIX_HEX) begin
        accum_nxt = {accum_r[ADDR_W-5:0], q_ent.val};
      end else if (q_ent.cls == CLS_DOT) begin
        if (count_r == 2'd3) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          parts_nxt[count_r] = accum_r;
          count_nxt          = count_r + 2'd1;
          accum_nxt          = '0;
          radix_nxt          = RADIX_DEC;
          phase_nxt          = PH_FIRST;
        end
      end else if (q_ent.cls == CLS_END) begin
        phase_nxt = PH_DONE;
        if (pr.rej) begin
          err_nxt = 1'b1;
        end else begin
          accum_nxt = pr.value;
        end
      end else begin
        err_nxt   = 1'b1;
        phase_nxt = PH_DONE;
      end
    end

    fin_nxt.accum = accum_nxt;
    fin_nxt.parts = parts_nxt;
    fin_nxt.count = count_nxt;
    fin_nxt.phase = phase_nxt;
    fin_nxt.err   = err_nxt;

    fin_valid_nxt = fin_valid_r && !fin_ready;
    if (pop && q_ent.last) begin
      fin_valid_nxt = 1'b1;
      // string handed on, start the next one from clean state
      accum_nxt = '0;
      parts_nxt = '0;
      count_nxt = '0;
      radix_nxt = RADIX_DEC;
      phase_nxt = PH_FIRST;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      parts_r     <= '0;
      count_r     <= '0;
      radix_r     <= RADIX_DEC;
      phase_r     <= PH_FIRST;
      err_r       <= 1'b0;
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
      if (pop) begin
        accum_r <= accum_nxt;
        parts_r <= parts_nxt;
        count_r <= count_nxt;
        radix_r <= radix_nxt;
        phase_r <= phase_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_ent.last) begin
      fin_r <= fin_nxt;
    end
  end

  a_clean_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_ent.last |=> phase_r == PH_FIRST && count_r == 2'd0 && !err_r && fin_valid_r)
    else $error("parser state not cleared after end of string");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_DONE)
    else $error("rejection without done phase");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r && !fin_ready |=> fin_valid_r && $stable(fin_r))
    else $error("finished string lost while packing stage stalled");

endmodule

/* rtl/core/ipda_pack.sv */
// end-of-string finish, byte swap and output register
module ipda_pack import ipda_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fin_valid,
  input  fin_t              fin,
  output logic              fin_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_address,
  output logic              out_ok
);

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              ok_r, ok_nxt;
  logic [ADDR_W-1:0] val;
  pack_res_t         pr;

  assign fin_ready   = !out_valid_r || out_ready;
  assign out_valid   = out_valid_r;
  assign out_address = addr_r;
  assign out_ok      = ok_r;

  always_comb begin
    pr  = ipda_finish(fin.accum, fin.parts, fin.count);
    val = fin.accum;
    // the implied nul after the last item
    unique case (fin.phase)
      PH_FIRST: ok_nxt = 1'b0;
      PH_LEAD0,
      PH_DIGITS: begin
        ok_nxt = !fin.err && !pr.rej;
        val    = pr.value;
      end
      default: ok_nxt = !fin.err;
    endcase
    addr_nxt      = ok_nxt ? {val[7:0], val[15:8], val[23:16], val[31:24]} : '0;
    out_valid_nxt = (out_valid_r && !out_ready) || fin_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      addr_r <= addr_nxt;
      ok_r   <= ok_nxt;
    end
  end

endmodule

/* rtl/core/ipv4_dotted_address_parser.sv */
// top level of the ipv4 dotted address parser
//
//  channel  direction  payload               handshake
//  in       input      in_ch, in_is_last     in_valid / in_ready
//  out      output     out_address, out_ok   out_valid / out_ready
//
// one character item per cycle sustained while the output is not stalled; after the
// last character is accepted its result passes the queue, parser and output registers
// synchronous active-low reset empties the queue and clears parser state
// a stalled output holds one result and the parser one more; the string after
// that keeps parsing until its last item waits and the two-entry queue fills
module ipv4_dotted_address_parser import ipda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_address,
  output logic        out_ok
);

  logic  push, q_ready, q_valid, pop, fin_valid, fin_ready;
  qent_t push_ent, q_ent;
  fin_t  fin;

  ipda_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .in_is_last (in_is_last),
    .push       (push),
    .push_ent   (push_ent),
    .q_ready    (q_ready)
  );

  ipda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_ent    (q_ent),
    .pop      (pop)
  );

  ipda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ent     (q_ent),
    .pop       (pop),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  ipda_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .fin_valid   (fin_valid),
    .fin         (fin),
    .fin_ready   (fin_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_address (out_address),
    .out_ok      (out_ok)
  );

endmodule

/* test/tb_ipv4_dotted_address_parser.sv */
// testbench for the ipv4 dotted address parser: character stream stimulus, scoreboard check
`timescale 1ns / 1ps

module tb_ipv4_dotted_address_parser;
  import ipda_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [31:0] address;
    logic        ok;
  } parse_result_t;

  // tracks the parser state and holds the addresses still owed by the block
  class dotted_addr_checker;
    logic [31:0]   accum;
    radix_t        radix;
    logic [31:0]   parts [3];
    logic [1:0]    nparts;
    phase_t        ph;
    bit            err;
    parse_result_t want_q[$];
    int            fails;
    int            chars_taken;

    function new();
      fails = 0;
      chars_taken = 0;
      clear();
    endfunction

    function void clear();
      accum = '0;
      radix = RADIX_DEC;
      foreach (parts[i]) parts[i] = '0;
      nparts = '0;
      ph = PH_FIRST;
      err = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function logic [7:0] upper(logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
    endfunction

    function void reject();
      err = 1'b1;
      ph = PH_DONE;
    endfunction

    // range check on the last part, earlier parts or-ed in as 32-bit shifts
    function void pack_parts();
      logic [31:0] v;
      v = accum;
      case (nparts)
        2'd0: ;
        2'd1: begin
          if (v > LIMIT_TWO) begin
            reject();
            return;
          end
          v = v | (parts[0] << 24);
        end
        2'd2: begin
          if (v > LIMIT_THREE) begin
            reject();
            return;
          end
          v = v | (parts[0] << 24) | (parts[1] << 16);
        end
        default: begin
          if (v > LIMIT_FOUR) begin
            reject();
            return;
          end
          v = v | (parts[0] << 24) | (parts[1] << 16) | (parts[2] << 8);
        end
      endcase
      accum = v;
      ph = PH_DONE;
    endfunction

    function void scan_digit(logic [7:0] c);
      logic [7:0]  u;
      logic [31:0] mul;
      u = upper(c);
      if (is_digit(c)) begin
        mul = (radix == RADIX_HEX) ? 32'd16 : (radix == RADIX_OCT) ? 32'd8 : 32'd10;
        accum = accum * mul + 32'(c - CH_ZERO);
      end else if (radix == RADIX_HEX && u >= CH_UP_A && u <= CH_UP_F) begin
        accum = (accum << 4) | 32'(u - CH_UP_A + 8'd10);
      end else if (c == CH_DOT) begin
        if (nparts == 2'd3) begin
          reject();
          return;
        end
        parts[nparts] = accum;
        nparts = nparts + 2'd1;
        accum = '0;
        radix = RADIX_DEC;
        ph = PH_FIRST;
      end else if (c == CH_NUL || is_blank(c)) begin
        pack_parts();
      end else begin
        reject();
      end
    endfunction

    function void step_char(logic [7:0] c);
      case (ph)
        PH_FIRST: begin
          if (!is_digit(c)) begin
            reject();
            return;
          end
          accum = '0;
          if (c == CH_ZERO) begin
            ph = PH_LEAD0;
          end else begin
            radix = RADIX_DEC;
            accum = 32'(c - CH_ZERO);
            ph = PH_DIGITS;
          end
        end
        PH_LEAD0: begin
          radix = (upper(c) == CH_UP_X) ? RADIX_HEX : RADIX_OCT;
          ph = PH_DIGITS;
          if (radix == RADIX_OCT) scan_digit(c);
        end
        PH_DIGITS: scan_digit(c);
        default: ;
      endcase
    endfunction

    function void take_char(logic [7:0] c, logic last);
      parse_result_t r;
      chars_taken++;
      step_char(c);
      if (last) begin
        step_char(CH_NUL);
        if (err || ph != PH_DONE) begin
          r.address = '0;
          r.ok = 1'b0;
        end else begin
          r.address = {accum[7:0], accum[15:8], accum[23:16], accum[31:24]};
          r.ok = 1'b1;
        end
        want_q.push_back(r);
        clear();
      end
    endfunction

    function void match_result(logic [31:0] address, logic ok);
      parse_result_t w;
      if (want_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, address %08h ok %0b",
                 $time, address, ok);
        fails++;
        return;
      end
      w = want_q.pop_front();
      if (address !== w.address) begin
        $display("%0t: address wrong, expected %08h, actual %08h", $time, w.address, address);
        fails++;
      end
      if (ok !== w.ok) begin
        $display("%0t: ok flag wrong, expected %0b, actual %0b", $time, w.ok, ok);
        fails++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_CHARS = 1600;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_address;
  logic        out_ok;

  dotted_addr_checker board;
  logic [7:0]         addr_text[$];
  char_item_t         char_stream[$];
  int                 idle_run = 0;

  ipv4_dotted_address_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ch       (in_ch),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_address (out_address),
    .out_ok      (out_ok)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
  endfunction

  // biased towards characters the parser cares about
  function automatic logic [7:0] junk_char();
    string pool;
    pool = "0123456789abcdefABCDEFxX. \t";
    if ($urandom_range(0, 1)) return 8'($urandom);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void put_dec(logic [31:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) addr_text.push_back(digs[i]);
  endfunction

  // octal digits now and then swapped for 8 or 9, which the parser still takes
  function automatic void put_oct(logic [31:0] v);
    logic [7:0] digs[$];
    addr_text.push_back(CH_ZERO);
    while (v != 0) begin
      if ($urandom_range(0, 7) == 0) digs.push_front(CH_ZERO + 8'($urandom_range(8, 9)));
      else digs.push_front(CH_ZERO + 8'(v[2:0]));
      v = v >> 3;
    end
    foreach (digs[i]) addr_text.push_back(digs[i]);
  endfunction

  function automatic void put_hex(logic [31:0] v);
    logic [7:0] digs[$];
    logic [7:0] ofs;
    addr_text.push_back(CH_ZERO);
    addr_text.push_back($urandom_range(0, 1) ? CH_UP_X : CH_UP_X + CASE_OFS);
    // bare prefix now and then
    if (v == 0 && $urandom_range(0, 1)) return;
    do begin
      ofs = $urandom_range(0, 1) ? CASE_OFS : 8'h00;
      if (v[3:0] < 4'd10) digs.push_front(CH_ZERO + 8'(v[3:0]));
      else digs.push_front(CH_UP_A + 8'(v[3:0]) - 8'd10 + ofs);
      v = v >> 4;
    end while (v != 0);
    if ($urandom_range(0, 5) == 0) digs.push_front(CH_ZERO);
    foreach (digs[i]) addr_text.push_back(digs[i]);
  endfunction

  function automatic void put_part(logic [31:0] v);
    case ($urandom_range(0, 2))
      0: put_dec(v);
      1: put_oct(v);
      default: put_hex(v);
    endcase
  endfunction

  function automatic void commit_string();
    char_item_t it;
    foreach (addr_text[i]) begin
      it.ch = addr_text[i];
      it.last = (i == addr_text.size() - 1);
      char_stream.push_back(it);
    end
    addr_text.delete();
  endfunction

  // monitor, scoreboard feed and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.take_char(in_ch, in_is_last);
      if (out_valid && out_ready) board.match_result(out_address, out_ok);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= IDLE_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // result side stalls; one long hold-off once traffic is flowing
  initial begin : result_sink
    int  cyc;
    int  hold;
    int  mode;
    bit  held_once;
    cyc = 0;
    hold = 0;
    mode = 0;
    held_once = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (!held_once && board != null && board.chars_taken >= 500) begin
        held_once = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= (cyc % 4 != 0);
          2: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : main
    char_item_t  it;
    int          burst;
    int          gap;
    int          n;
    int          pos;
    int          len;
    int          r;
    logic [31:0] v;
    logic [31:0] lim;

    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ch <= 8'h00;
    in_is_last <= 1'b0;

    // directed strings
    put_text("0");                   commit_string();
    put_text("255.0xFf.077.9");      commit_string();
    put_text("0x");                  commit_string();
    put_text("089");                 commit_string();
    put_text("1.2.3.256");           commit_string();
    put_text("1.2.65536");           commit_string();
    put_text("1.2.3.4.5");           commit_string();
    put_text(".5");                  commit_string();
    put_text("9z");                  commit_string();
    put_text("4294967296");          commit_string();
    put_text("1\t9");                commit_string();
    addr_text.push_back(8'hff);      commit_string();
    put_text("7");
    addr_text.push_back(CH_NUL);
    put_text("zz");                  commit_string();
    put_text("3.");                  commit_string();

    n = char_stream.size();
    while (char_stream.size() < n + RANDOM_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed address with random content, sometimes damaged
        len = $urandom_range(1, 4);
        for (int i = 0; i < len - 1; i++) begin
          put_part(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 255));
          addr_text.push_back(CH_DOT);
        end
        case (len)
          1: lim = 32'hffff_ffff;
          2: lim = LIMIT_TWO;
          3: lim = LIMIT_THREE;
          default: lim = LIMIT_FOUR;
        endcase
        case ($urandom_range(0, 3))
          0: v = $urandom & lim;
          1: v = lim;
          2: v = (len == 1) ? $urandom : lim + 32'($urandom_range(1, 3));
          default: v = $urandom_range(0, 9);
        endcase
        put_part(v);
        case ($urandom_range(0, 9))
          0: begin
            addr_text.push_back($urandom_range(0, 1) ? CH_SPACE
                                : CH_TAB + 8'($urandom_range(0, 4)));
            repeat ($urandom_range(0, 3)) addr_text.push_back(junk_char());
          end
          1: begin
            addr_text.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) addr_text.push_back(junk_char());
          end
          default: ;
        endcase
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, addr_text.size() - 1);
          case ($urandom_range(0, 3))
            0: addr_text.insert(pos, junk_char());
            1: if (addr_text.size() > 1) addr_text.delete(pos);
            2: addr_text[pos] = junk_char();
            default: addr_text.push_back(CH_DOT);
          endcase
        end
      end else if (r < 85) begin
        // long digit runs so the accumulator wraps
        if ($urandom_range(0, 1)) begin
          put_dec($urandom_range(0, 255));
          addr_text.push_back(CH_DOT);
        end
        r = $urandom_range(0, 2);
        if (r > 0) addr_text.push_back(CH_ZERO);
        if (r == 2) addr_text.push_back(CH_UP_X);
        len = $urandom_range(9, 16);
        for (int i = 0; i < len; i++) begin
          if (r == 2) begin
            v = $urandom_range(0, 15);
            addr_text.push_back(v < 10 ? CH_ZERO + 8'(v) : CH_LO_A + 8'(v) - 8'd10);
          end else begin
            addr_text.push_back(CH_ZERO + 8'((r == 0 && i == 0) ? $urandom_range(1, 9)
                                                                : $urandom_range(0, 9)));
          end
        end
      end else begin
        repeat ($urandom_range(1, 12)) addr_text.push_back(junk_char());
      end
      commit_string();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // sender: bursts of items with random gaps
    while (char_stream.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && char_stream.size() > 0) begin
        it = char_stream.pop_front();
        in_valid <= 1'b1;
        in_ch <= it.ch;
        in_is_last <= it.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* ipv4_dotted_address_parser.f */
rtl/core/ipda_pkg.sv
rtl/core/ipda_front.sv
rtl/core/ipda_queue.sv
rtl/core/ipda_back.sv
rtl/core/ipda_pack.sv
rtl/core/ipv4_dotted_address_parser.sv
test/tb_ipv4_dotted_address_parser.sv
